@@ hw/rtl/grc_pkg.sv @@
// Package for the grid ray cast column core: sizes, register indexes, divider request and response types.
// Used by every module of the block; depends on nothing.
`default_nettype none
package grc_pkg;
  localparam int unsigned ScreenW  = 320;
  localparam int unsigned ScreenH  = 240;
  localparam int unsigned MapW     = 16;
  localparam int unsigned MapH     = 16;
  localparam int unsigned MaxSteps = 32;

  localparam logic [2:0] REG_POS_X   = 3'd0;
  localparam logic [2:0] REG_POS_Y   = 3'd1;
  localparam logic [2:0] REG_DIR_X   = 3'd2;
  localparam logic [2:0] REG_DIR_Y   = 3'd3;
  localparam logic [2:0] REG_PLANE_X = 3'd4;
  localparam logic [2:0] REG_PLANE_Y = 3'd5;

  typedef struct packed {
    logic        start;
    logic [33:0] num;
    logic [33:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [33:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

@@ hw/rtl/grc_div.sv @@
// Shared restoring divider of the ray cast core, one quotient bit per cycle.
// Depends on grc_pkg.
`default_nettype none
module grc_div
  import grc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);
  logic [33:0] quo_q, quo_d, den_q, den_d;
  logic [34:0] rem_q, rem_d, trial;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;

  always_comb begin
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[33:0], quo_q[33]} - {1'b0, den_q};
    if (req_i.start) begin
      quo_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      cnt_d  = 6'd34;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[34]) begin
        rem_d = trial;
        quo_d = {quo_q[32:0], 1'b1};
      end else begin
        rem_d = {rem_q[33:0], quo_q[33]};
        quo_d = {quo_q[32:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |-> $past(busy_q)) else $error("divider done without work");
  a_cnt_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q && !req_i.start |=> !busy_q) else $error("divider started by itself");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start) else $error("divider restarted while busy");
`endif
endmodule
`default_nettype wire

@@ hw/rtl/grid_ray_cast_column_core.sv @@
// Top level of the grid ray cast column core: sequencer, map, camera registers.
// Depends on grc_pkg and grc_div.
//
// Use: the input channel carries a load word (action 0) that writes one map row,
// or a cast word (action 1) holding a screen column. Each cast gives one output
// word with the clamped draw rows, the hit side and the Q8.8 wall distance.
// Loads give no output. Camera registers are written through the plain write
// port; the user must write them only while the core is idle, which the core
// itself does not enforce. A load is taken without leaving idle, so the core
// stays ready. A cast runs in order through the camera and ray multiplies, two
// ray delta divisions, the side distance multiplies and walk setup, one step per
// cell walked (1 to MAX_STEPS cells), one height division and the output state;
// only then does the core return to idle and take the next word. One shared
// multiplier and one shared divider serve all of these steps.
// A finished result sits in the output register until taken; a new word is
// accepted while it waits, but the next cast holds before its end until the
// output is free.
// Reset clears the map to all zero and loads the default camera.
`default_nettype none
module grid_ray_cast_column_core
  import grc_pkg::*;
#(
  parameter int unsigned SCREEN_W  = ScreenW,
  parameter int unsigned SCREEN_H  = ScreenH,
  parameter int unsigned MAP_W     = MapW,
  parameter int unsigned MAP_H     = MapH,
  parameter int unsigned MAX_STEPS = MaxSteps
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        action_i,
  input  wire logic [3:0]  row_index_i,
  input  wire logic [15:0] row_bits_i,
  input  wire logic [9:0]  screen_column_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [9:0]       column_out_o,
  output logic [9:0]       draw_start_o,
  output logic [9:0]       draw_end_o,
  output logic             hit_side_o,
  output logic [15:0]      wall_distance_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  localparam int StepW = $clog2(MAX_STEPS + 1);
  localparam logic [StepW-1:0] StepMax = StepW'(MAX_STEPS);
  localparam logic [33:0] HeightMax = 34'(2 * SCREEN_H + 2);
  localparam logic [10:0] HalfH = 11'(SCREEN_H / 2);
  localparam logic [10:0] LastRow = 11'(SCREEN_H - 1);
  localparam logic [33:0] HNum = 34'(SCREEN_H) << 16;
  // Scaled reciprocal of the screen width; column times it, shifted right by 20,
  // gives the exact floor of column * 32768 / SCREEN_W.
  localparam logic [35:0] CamRecip =
    36'(((64'd1 << 35) + 64'(SCREEN_W) - 64'd1) / 64'(SCREEN_W));

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CAM  = 4'd1;
  localparam logic [3:0] S_CAMQ = 4'd2;
  localparam logic [3:0] S_RX   = 4'd3;
  localparam logic [3:0] S_RY   = 4'd4;
  localparam logic [3:0] S_DX   = 4'd5;
  localparam logic [3:0] S_DY   = 4'd6;
  localparam logic [3:0] S_SX   = 4'd7;
  localparam logic [3:0] S_SY   = 4'd8;
  localparam logic [3:0] S_WALK = 4'd9;
  localparam logic [3:0] S_HT   = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]  state_q, state_d;
  logic [15:0] pos_x_q, pos_y_q, dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic [15:0] map_q [16];
  logic [9:0]  col_q;
  logic signed [24:0] cam_q;
  logic signed [27:0] rx_q, ry_q;
  logic [31:0] dx_q, dy_q;
  logic [37:0] sx_q, sy_q;
  logic signed [5:0] mx_q, my_q;
  logic        side_q;
  logic [StepW-1:0] n_q;
  logic [37:0] dist_q;
  logic        ov_q;
  logic [9:0]  ocol_q, ostart_q, oend_q;
  logic        oside_q;
  logic [15:0] odist_q;

  // shared multiplier
  logic signed [18:0] mul_a;
  logic signed [35:0] mul_b;
  logic signed [54:0] mul_p;
  logic signed [54:0] prod_q;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     div_started_q;

  grc_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));

  logic in_acc, cast_acc;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign cast_acc   = in_acc && action_i;

  logic [27:0] arx, ary;
  assign arx = rx_q[27] ? 28'(-rx_q) : 28'(rx_q);
  assign ary = ry_q[27] ? 28'(-ry_q) : 28'(ry_q);

  logic signed [24:0] cam_w;
  logic signed [27:0] floor_rx;
  logic [12:0] frac_x, frac_y;
  assign frac_x = rx_q[27] ? {1'b0, pos_x_q[11:0]} : 13'd4096 - {1'b0, pos_x_q[11:0]};
  assign frac_y = ry_q[27] ? {1'b0, pos_y_q[11:0]} : 13'd4096 - {1'b0, pos_y_q[11:0]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_CAM: begin
        mul_a = 19'(col_q);
        mul_b = signed'(CamRecip);
      end
      S_RX: begin
        mul_a = 19'(signed'(plane_x_q));
        mul_b = 36'(cam_q);
      end
      S_RY: begin
        mul_a = 19'(signed'(plane_y_q));
        mul_b = 36'(cam_q);
      end
      S_SX: begin
        mul_a = 19'(frac_x);
        mul_b = 36'({1'b0, dx_q});
      end
      S_SY: begin
        mul_a = 19'(frac_y);
        mul_b = 36'({1'b0, dy_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // walk step
  logic        step_x;
  logic signed [5:0] nmx, nmy;
  logic [37:0] nsx, nsy;
  logic        out_map, wall;
  logic [15:0] row_sel;
  always_comb begin
    step_x = sx_q < sy_q;
    nmx = mx_q;
    nmy = my_q;
    nsx = sx_q;
    nsy = sy_q;
    if (step_x) begin
      nsx = sx_q + 38'(dx_q);
      nmx = rx_q[27] ? mx_q - 6'sd1 : mx_q + 6'sd1;
    end else begin
      nsy = sy_q + 38'(dy_q);
      nmy = ry_q[27] ? my_q - 6'sd1 : my_q + 6'sd1;
    end
    out_map = nmx < 0 || nmx >= 6'(MAP_W) || nmy < 0 || nmy >= 6'(MAP_H);
    row_sel = map_q[nmy[3:0]];
    wall    = row_sel[nmx[3:0]];
  end

  logic [33:0] hgt;
  logic [10:0] half;
  assign hgt  = (dist_q == '0 || div_rsp.quo > HeightMax) ? HeightMax : div_rsp.quo;
  assign half = 11'(hgt >> 1);

  always_comb begin
    state_d = state_q;
    div_req = '0;
    unique case (state_q)
      S_IDLE: if (cast_acc) state_d = S_CAM;
      S_CAM:  state_d = S_CAMQ;
      S_CAMQ: state_d = S_RX;
      S_RX:   state_d = S_RY;
      S_RY:   state_d = S_DX;
      S_DX: begin
        if (!div_started_q) begin
          div_req.start = 1'b1;
          div_req.num   = 34'd1 << 30;
          div_req.den   = 34'(arx);
        end
        if (div_rsp.done) state_d = S_DY;
      end
      S_DY: begin
        if (!div_started_q) begin
          div_req.start = 1'b1;
          div_req.num   = 34'd1 << 30;
          div_req.den   = 34'(ary);
        end
        if (div_rsp.done) state_d = S_SX;
      end
      S_SX: state_d = S_SY;
      S_SY: state_d = S_WALK;
      S_WALK: begin
        if (n_q != '0 && (out_map || wall || n_q == StepMax)) state_d = S_HT;
      end
      S_HT: begin
        if (!div_started_q) begin
          div_req.start = 1'b1;
          div_req.num   = HNum;
          div_req.den   = (dist_q[37:34] != '0) ? '1 : dist_q[33:0];
        end
        if (div_rsp.done) state_d = S_OUT;
      end
      S_OUT: if (!ov_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign cam_w    = 25'(prod_q >>> 20) - 25'sd16384;
  assign floor_rx = 28'(prod_q >>> 14);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      div_started_q <= 1'b0;
      ov_q          <= 1'b0;
      pos_x_q   <= 16'd16384;
      pos_y_q   <= 16'd16384;
      dir_x_q   <= 16'd16384;
      dir_y_q   <= 16'd0;
      plane_x_q <= 16'd0;
      plane_y_q <= 16'd10813;
      for (int i = 0; i < 16; i++) map_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (div_req.start) div_started_q <= 1'b1;
      else if (div_rsp.done) div_started_q <= 1'b0;
      if (state_q == S_OUT && (!ov_q || out_ready_i)) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      if (in_acc && !action_i) map_q[row_index_i] <= row_bits_i;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_POS_X:   pos_x_q   <= cfg_data_i;
          REG_POS_Y:   pos_y_q   <= cfg_data_i;
          REG_DIR_X:   dir_x_q   <= cfg_data_i;
          REG_DIR_Y:   dir_y_q   <= cfg_data_i;
          REG_PLANE_X: plane_x_q <= cfg_data_i;
          REG_PLANE_Y: plane_y_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    unique case (state_q)
      S_IDLE: if (cast_acc) col_q <= screen_column_i;
      S_CAM: ;
      S_CAMQ: cam_q <= cam_w;
      S_RX: ;
      S_RY: rx_q <= signed'({{12{dir_x_q[15]}}, dir_x_q}) + floor_rx;
      S_DX: begin
        if (div_req.start) ry_q <= signed'({{12{dir_y_q[15]}}, dir_y_q}) + floor_rx;
        if (div_rsp.done) dx_q <= (arx == '0) ? 32'hFFFF_FFFF : div_rsp.quo[31:0];
      end
      S_DY: if (div_rsp.done) dy_q <= (ary == '0) ? 32'hFFFF_FFFF : div_rsp.quo[31:0];
      S_SX: begin
        mx_q   <= 6'(pos_x_q[15:12]);
        my_q   <= 6'(pos_y_q[15:12]);
        side_q <= 1'b1;
        n_q    <= '0;
      end
      S_SY: sx_q <= 38'(prod_q >>> 12);
      S_WALK: begin
        if (n_q == '0) begin
          sy_q <= 38'(prod_q >>> 12);
        end else begin
          sx_q <= nsx;
          sy_q <= nsy;
          mx_q <= nmx;
          my_q <= nmy;
          side_q <= ~step_x;
          dist_q <= step_x ? sx_q : sy_q;
        end
      end
      S_HT: ;
      S_OUT: if (!ov_q || out_ready_i) begin
        ocol_q   <= col_q;
        ostart_q <= (half > HalfH) ? 10'd0 : 10'(HalfH - half);
        oend_q   <= (HalfH + half > LastRow) ? 10'(LastRow) : 10'(HalfH + half);
        oside_q  <= side_q;
        odist_q  <= (dist_q[37:24] != '0) ? 16'hFFFF : dist_q[23:8];
      end
      default: ;
    endcase
    if (state_q == S_WALK && n_q == '0) n_q <= StepW'(1);
    else if (state_q == S_WALK) n_q <= n_q + StepW'(1);
  end

  assign out_valid_o     = ov_q;
  assign column_out_o    = ocol_q;
  assign draw_start_o    = ostart_q;
  assign draw_end_o      = oend_q;
  assign hit_side_o      = oside_q;
  assign wall_distance_o = odist_q;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("output dropped");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> n_q <= StepMax) else $error("walk past step limit");
`endif
endmodule
`default_nettype wire
